// File: rtl/core/ratl_pkg.sv
// ----------------------------------------------------------------------------
// ratl_pkg
// Shared types and constants of the range alias table lookup block.
// ----------------------------------------------------------------------------
package ratl_pkg;

    localparam int ENTRIES_DEF  = 256;
    localparam int TAG_BITS_DEF = 16;

    // Request and result field widths
    localparam int OP_W     = 2;
    localparam int ID_W     = 32;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam int S_DATA_W = 120;  // 115 bits of fields, padded to bytes
    localparam int M_DATA_W = 32;   // 28 bits of fields, padded to bytes

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Controller to scan unit
    typedef struct packed {
        logic start;   // clear the running best at the start of a lookup
        logic valid;   // entry data from memory is live this cycle
    } scan_ctl_t;

    // Scan unit to controller
    typedef struct packed {
        logic have;        // some entry covers the search id so far
        logic single_hit;  // the entry in flight is a covering single id
    } scan_stat_t;

endpackage

// File: rtl/core/ratl_ram.sv
// ----------------------------------------------------------------------------
// ratl_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ratl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/ratl_scan.sv
// ----------------------------------------------------------------------------
// ratl_scan
// Match unit: tests one stored entry per cycle and keeps a covering single id or the narrowest range.
// ----------------------------------------------------------------------------
module ratl_scan
    import ratl_pkg::*;
#(
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  scan_ctl_t           ctl,
    input  logic [ID_W-1:0]     search_id,
    input  logic [ID_W-1:0]     ent_low,
    input  logic [ID_W-1:0]     ent_high,
    input  logic                ent_range,
    input  logic [TAG_BITS-1:0] ent_tag,
    output scan_stat_t          stat,
    output logic [TAG_BITS-1:0] best_tag
);

    logic                have_reg, have_next;
    logic [ID_W-1:0]     width_reg, width_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic                covers;
    logic [ID_W-1:0]     ent_width;

    assign covers    = (search_id >= ent_low) && (search_id <= ent_high);
    assign ent_width = ent_high - ent_low;

    always_comb begin
        have_next  = have_reg;
        width_next = width_reg;
        tag_next   = tag_reg;
        if (ctl.start) begin
            have_next = 1'b0;
        end else if (ctl.valid && covers) begin
            if (!ent_range) begin
                // single id wins outright; the controller stops the scan
                have_next = 1'b1;
                tag_next  = ent_tag;
            end else if (!have_reg || (ent_width < width_reg)) begin
                have_next  = 1'b1;
                width_next = ent_width;
                tag_next   = ent_tag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else begin
            have_reg <= have_next;
        end
        width_reg <= width_next;
        tag_reg   <= tag_next;
    end

    assign stat.have       = have_reg;
    assign stat.single_hit = ctl.valid && covers && !ent_range;
    assign best_tag        = tag_reg;

endmodule

// File: rtl/core/range_alias_table_lookup.sv
// ----------------------------------------------------------------------------
// range_alias_table_lookup
// Alias table of ID ranges with first-single / narrowest-range lookup.
// ----------------------------------------------------------------------------
// Append, clear and unused ops: result loads into the output register at the
// accept edge; one request per cycle while the result side keeps draining.
// Lookup: reads the stored entries in order from the registered RAM and tests
// each one; the scan ends when all are tested or a single ID hits, and the
// result posts once the output slot is free; an empty table skips the scan.
// Reset (aresetn low, synchronous) empties the table and the output register;
// the entry memory is not cleared, entries past the fill count are never read.
// ----------------------------------------------------------------------------
module range_alias_table_lookup
    import ratl_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Request channel
    input  logic                s_tvalid,
    output logic                s_tready,
    // [1:0] op, [33:2] range_low, [65:34] range_high, [66] span_flag,
    // [82:67] name_tag, [114:83] search_id, [119:115] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    // Result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    // [1:0] status, [2] found, [18:3] match_tag, [27:19] entry_count,
    // [31:28] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW     = $clog2(ENTRIES + 1);
    localparam int WORD_W = 2 * ID_W + 1 + TAG_BITS;

    // ---------------------------------------------------------------- fields
    logic [OP_W-1:0]     in_op;
    logic [ID_W-1:0]     in_low;
    logic [ID_W-1:0]     in_high;
    logic                in_range;
    logic [TAG_W-1:0]    in_name_tag;
    logic [ID_W-1:0]     in_search_id;
    logic [31:0]         in_tag_wide;
    logic [TAG_BITS-1:0] in_tag;

    assign in_op        = s_tdata[1:0];
    assign in_low       = s_tdata[33:2];
    assign in_high      = s_tdata[65:34];
    assign in_range     = s_tdata[66];
    assign in_name_tag  = s_tdata[82:67];
    assign in_search_id = s_tdata[114:83];

    // Mask the tag to the stored width
    assign in_tag_wide  = 32'(in_name_tag);
    assign in_tag       = in_tag_wide[TAG_BITS-1:0];

    // ------------------------------------------------------------ registers
    state_t          state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [CW-1:0]   issue_reg, issue_next;    // entries read so far in a scan
    logic            rd_valid_reg, rd_valid_next;
    logic [ID_W-1:0] sid_reg, sid_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_found_reg, out_found_next;
    logic [TAG_W-1:0]    out_tag_reg, out_tag_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    // --------------------------------------------------------- handshakes
    logic accept;
    logic out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------ append checks
    logic append_bad;
    logic table_full;

    assign append_bad = (in_tag == '0) || (in_low > in_high)
                     || (!in_range && (in_low != in_high));
    assign table_full = (fill_reg >= CW'(ENTRIES));

    // ------------------------------------------------------------- memory
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // Entry word: {span_flag, tag, high, low}
    assign ram_waddr = fill_reg[AW-1:0];
    assign ram_wdata = {in_range, in_tag, in_high, in_low};
    assign ram_raddr = issue_reg[AW-1:0];

    ratl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ---------------------------------------------------------- scan unit
    scan_ctl_t           scan_ctl;
    scan_stat_t          scan_stat;
    logic [TAG_BITS-1:0] scan_best_tag;
    logic [31:0]         best_tag_wide;

    ratl_scan #(
        .TAG_BITS (TAG_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .search_id (sid_reg),
        .ent_low   (ram_rdata[ID_W-1:0]),
        .ent_high  (ram_rdata[2*ID_W-1:ID_W]),
        .ent_range (ram_rdata[WORD_W-1]),
        .ent_tag   (ram_rdata[WORD_W-2:2*ID_W]),
        .stat      (scan_stat),
        .best_tag  (scan_best_tag)
    );

    assign best_tag_wide = 32'(scan_best_tag);

    // Scan is over once every stored entry has been read and tested
    logic scan_end;
    assign scan_end = (issue_reg == fill_reg) && !rd_valid_reg;

    // --------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (in_op == OP_LOOKUP)) begin
                    // empty table: nothing to read, post right away
                    state_next = (fill_reg == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_stat.single_hit || scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------ outputs
    // Fit a fill count into the entry_count field
    function automatic logic [COUNT_W-1:0] count_field(input logic [CW-1:0] n);
        logic [31:0] n_wide;
        n_wide = 32'(n);
        return n_wide[COUNT_W-1:0];
    endfunction

    always_comb begin
        s_tready        = 1'b0;
        ram_we          = 1'b0;
        scan_ctl        = '0;
        fill_next       = fill_reg;
        issue_next      = issue_reg;
        rd_valid_next   = 1'b0;
        sid_next        = sid_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_tag_next    = out_tag_reg;
        out_count_next  = out_count_reg;

        case (state_reg)
            ST_IDLE: begin
                // take a request only when the output slot frees this cycle
                s_tready = out_free;
                if (accept) begin
                    out_status_next = STAT_OK;
                    out_found_next  = 1'b0;
                    out_tag_next    = '0;
                    case (in_op)
                        OP_APPEND: begin
                            if (append_bad) begin
                                out_status_next = STAT_INVALID;
                            end else if (table_full) begin
                                out_status_next = STAT_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + CW'(1);
                            end
                            out_valid_next = 1'b1;
                        end
                        OP_LOOKUP: begin
                            // hold the search id, reset the scan
                            sid_next       = in_search_id;
                            issue_next     = '0;
                            scan_ctl.start = 1'b1;
                        end
                        OP_CLEAR: begin
                            fill_next      = '0;
                            out_valid_next = 1'b1;
                        end
                        default: begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                    out_count_next = count_field(fill_next);
                end
            end
            ST_SCAN: begin
                // issue the next read and test the entry read last cycle
                scan_ctl.valid = rd_valid_reg;
                if (issue_reg != fill_reg) begin
                    issue_next    = issue_reg + CW'(1);
                    rd_valid_next = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_found_next  = scan_stat.have;
                    out_tag_next    = scan_stat.have ? best_tag_wide[TAG_W-1:0] : '0;
                    out_count_next  = count_field(fill_reg);
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            issue_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
        sid_reg        <= sid_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_tag_reg    <= out_tag_next;
        out_count_reg  <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_count_reg, out_tag_reg, out_found_reg, out_status_reg};

endmodule

// File: tb/alias_table_checker.sv
// ----------------------------------------------------------------------------
// alias_table_checker
// Watches both channels of the alias table, keeps a shadow table of its own,
// predicts one result per accepted request and compares the results in order.
// ----------------------------------------------------------------------------
module alias_table_checker
    import ratl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t            status;
        logic               found;
        logic [TAG_W-1:0]   match_tag;
        logic [COUNT_W-1:0] entry_count;
    } alias_result_t;

    logic [ID_W-1:0]  low_bound  [ENTRIES_DEF];
    logic [ID_W-1:0]  high_bound [ENTRIES_DEF];
    logic             range_flag [ENTRIES_DEF];
    logic [TAG_W-1:0] alias_tag  [ENTRIES_DEF];
    int               stored;
    int               mismatches;
    alias_result_t    expected_results[$];

    // Apply one request to the shadow table and return the result it causes.
    function automatic alias_result_t apply_request(input logic [S_DATA_W-1:0] req);
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  lo;
        logic [ID_W-1:0]  hi;
        logic [ID_W-1:0]  sid;
        logic [ID_W-1:0]  width;
        logic [ID_W-1:0]  best_width;
        logic             is_rng;
        logic             single_hit;
        logic [TAG_W-1:0] tag;
        alias_result_t    res;
        op     = req[1:0];
        lo     = req[33:2];
        hi     = req[65:34];
        is_rng = req[66];
        tag    = req[82:67];
        sid    = req[114:83];
        res    = '{status: STAT_OK, found: 1'b0, match_tag: '0, entry_count: '0};
        case (op)
            OP_APPEND: begin
                if (tag == '0 || lo > hi || (!is_rng && lo != hi)) begin
                    res.status = STAT_INVALID;
                end else if (stored >= ENTRIES_DEF) begin
                    res.status = STAT_FULL;
                end else begin
                    low_bound[stored]  = lo;
                    high_bound[stored] = hi;
                    range_flag[stored] = is_rng;
                    alias_tag[stored]  = tag;
                    stored++;
                end
            end
            OP_LOOKUP: begin
                // a covering single id ends the scan; otherwise keep the
                // first of the narrowest covering ranges
                single_hit = 1'b0;
                best_width = '0;
                for (int i = 0; i < stored && !single_hit; i++) begin
                    if (sid >= low_bound[i] && sid <= high_bound[i]) begin
                        width = high_bound[i] - low_bound[i];
                        if (!range_flag[i]) begin
                            single_hit    = 1'b1;
                            res.found     = 1'b1;
                            res.match_tag = alias_tag[i];
                        end else if (!res.found || width < best_width) begin
                            res.found     = 1'b1;
                            res.match_tag = alias_tag[i];
                            best_width    = width;
                        end
                    end
                end
            end
            OP_CLEAR: stored = 0;
            default: ;
        endcase
        res.entry_count = stored[COUNT_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        alias_result_t want;
        alias_result_t got;
        if (!aresetn) begin
            stored = 0;
            expected_results.delete();
        end else begin
            // check the result first: it always belongs to an earlier request
            if (m_tvalid && m_tready) begin
                got.status      = status_t'(m_tdata[1:0]);
                got.found       = m_tdata[2];
                got.match_tag   = m_tdata[18:3];
                got.entry_count = m_tdata[27:19];
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result status %0d found %b tag %h count %0d",
                                 $realtime, got.status, got.found, got.match_tag,
                                 got.entry_count);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.found !== want.found ||
                        got.match_tag !== want.match_tag ||
                        got.entry_count !== want.entry_count) begin
                        // fields shown as status/found/tag/count
                        if (mismatches < 10)
                            $display("%0t: result exp %0d/%b/%h/%0d got %0d/%b/%h/%0d",
                                     $realtime,
                                     want.status, want.found, want.match_tag, want.entry_count,
                                     got.status, got.found, got.match_tag, got.entry_count);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(s_tdata));
        end
        pending    <= expected_results.size();
        fail_count <= mismatches;
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives append, lookup, clear and unused requests into the alias table with
// random gaps and result-side stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import ratl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;  // op code the block ignores

    localparam int TOTAL_ITEMS   = 650;
    localparam int QUIET_ITEMS   = 60;      // tail of the run without idling
    localparam int HOLD_CYCLES   = 200;     // long result-side hold-off
    localparam int SETTLE_CYCLES = 300;     // beyond the longest lookup scan
    localparam int DRAIN_LIMIT   = 100000;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    int                  fail_count;
    int                  pending;

    bit                  quiet;         // no idling on either side
    bit                  hold_request;  // ask the receiver for a long hold-off
    int                  idle_odds;     // 0: sender never idles
    int                  sent;
    logic [ID_W-1:0]     known_low[$];  // bounds of appended entries, for targeting
    logic [ID_W-1:0]     known_high[$];

    range_alias_table_lookup u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    alias_table_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Random filler for fields a request does not use.
    function automatic logic [TAG_W-1:0] rnd_tag();
        return TAG_W'($urandom);
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one request from a falling edge and hold it until accepted.
    // Return at the falling edge after the accepting rising edge.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] lo,
                                input logic [ID_W-1:0] hi, input logic is_rng,
                                input logic [TAG_W-1:0] tag, input logic [ID_W-1:0] sid);
        int gap;
        if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        // pad, search_id, name_tag, span_flag, range_high, range_low, op
        s_tdata  <= {5'd0, sid, tag, is_rng, hi, lo, op};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
        sent++;
    endtask

    // Pick a neighborhood for a batch of entries: the bottom, the top or anywhere.
    function automatic logic [ID_W-1:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 32'hFFFF_FFC0;
            default: return $urandom;
        endcase
    endfunction

    // Build a well-formed entry near base; ranges mostly short so they nest.
    task automatic make_entry(input logic [ID_W-1:0] base, output logic [ID_W-1:0] lo,
                              output logic [ID_W-1:0] hi, output logic is_rng,
                              output logic [TAG_W-1:0] tag);
        logic [ID_W:0] top_end;
        lo = base + $urandom_range(0, 40);
        if ($urandom_range(0, 9) < 3) begin
            is_rng = 1'b0;
            hi     = lo;
        end else begin
            is_rng  = 1'b1;
            top_end = {1'b0, lo} + (ID_W + 1)'(($urandom_range(0, 7) == 0)
                                               ? $urandom : $urandom_range(0, 40));
            hi      = top_end[ID_W] ? '1 : top_end[ID_W-1:0];
        end
        tag = ($urandom_range(0, 15) == 0) ? '1 : TAG_W'($urandom_range(1, 16'hFFFF));
    endtask

    // Search id on, just outside, or inside a known entry.
    function automatic logic [ID_W-1:0] lookup_target();
        int          k;
        logic [63:0] span;
        if (known_low.size() == 0)
            return $urandom;
        k    = $urandom_range(0, known_low.size() - 1);
        span = {32'd0, known_high[k]} - {32'd0, known_low[k]} + 64'd1;
        case ($urandom_range(0, 4))
            0:       return known_low[k];
            1:       return known_high[k];
            2:       return known_low[k] - 1;
            3:       return known_high[k] + 1;
            default: return known_low[k] + ID_W'({$urandom, $urandom} % span);
        endcase
    endfunction

    // One batch: optional clear, some appends (a few malformed), then lookups
    // with a little noise mixed in.
    task automatic run_table_session(input bit wipe);
        int               n_add;
        int               n_find;
        int               pick;
        logic [ID_W-1:0]  base;
        logic [ID_W-1:0]  lo;
        logic [ID_W-1:0]  hi;
        logic             is_rng;
        logic [TAG_W-1:0] tag;
        idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
        if (wipe) begin
            send_request(OP_CLEAR, $urandom, $urandom, rnd_bit(), rnd_tag(), $urandom);
            known_low.delete();
            known_high.delete();
        end
        base  = pick_base();
        n_add = $urandom_range(1, 12);
        repeat (n_add) begin
            pick = $urandom_range(0, 19);
            if (pick < 4) begin
                is_rng = rnd_bit();
                tag    = TAG_W'($urandom_range(1, 16'hFFFF));
                case (pick)
                    0: begin  // empty tag
                        lo  = $urandom;
                        hi  = lo;
                        tag = '0;
                    end
                    1: begin  // bounds inverted
                        hi = $urandom >> 1;
                        lo = hi + 1 + ($urandom >> 1);
                    end
                    default: begin  // single id with differing bounds
                        lo     = $urandom;
                        hi     = lo ^ (32'd1 << $urandom_range(0, 31));
                        is_rng = 1'b0;
                    end
                endcase
            end else begin
                make_entry(base, lo, hi, is_rng, tag);
                known_low.push_back(lo);
                known_high.push_back(hi);
            end
            send_request(OP_APPEND, lo, hi, is_rng, tag, $urandom);
        end
        n_find = $urandom_range(2, 12);
        repeat (n_find) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_request(OP_UNUSED, $urandom, $urandom, rnd_bit(), rnd_tag(),
                             $urandom);
            else if (pick == 1)
                send_request(OP_W'($urandom_range(0, 3)), $urandom, $urandom,
                             rnd_bit(), rnd_tag(), $urandom);
            else
                send_request(OP_LOOKUP, $urandom, $urandom, rnd_bit(), rnd_tag(),
                             (pick < 5) ? $urandom : lookup_target());
        end
    endtask

    // Result side: random stall bursts, calm stretches, one long hold-off.
    initial begin
        int stall_left;
        int calm_left;
        bit calm;
        m_tready   = 1'b0;
        stall_left = 0;
        calm_left  = 0;
        calm       = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(20, 120);
            end
            calm_left--;
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Request side and verdict.
    initial begin
        logic [ID_W-1:0]  base;
        logic [ID_W-1:0]  lo;
        logic [ID_W-1:0]  hi;
        logic             is_rng;
        logic [TAG_W-1:0] tag;
        int               session;
        int               waited;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        idle_odds    = 4;
        sent         = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // lookup on an empty table, then an op code the block ignores
        send_request(OP_LOOKUP, $urandom, $urandom, 1'b1, 16'hFFFF, 32'd0);
        send_request(OP_UNUSED, 32'd5, 32'd5, 1'b0, 16'h0001, $urandom);
        // malformed appends: empty tag, inverted bounds, single with two bounds
        send_request(OP_APPEND, 32'd5, 32'd5, 1'b0, 16'h0000, $urandom);
        send_request(OP_APPEND, 32'hFFFF_FFFF, 32'd0, 1'b1, 16'h0001, $urandom);
        send_request(OP_APPEND, 32'd5, 32'd6, 1'b0, 16'h0001, $urandom);
        // full span, two overlapping ranges of equal width, a narrow one inside
        send_request(OP_APPEND, 32'd0, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, $urandom);
        send_request(OP_APPEND, 32'd100, 32'd200, 1'b1, 16'h0001, $urandom);
        send_request(OP_APPEND, 32'd150, 32'd250, 1'b1, 16'h0002, $urandom);
        send_request(OP_APPEND, 32'd120, 32'd130, 1'b1, 16'h0003, $urandom);
        // zero-width range ahead of two singles on the same id
        send_request(OP_APPEND, 32'd160, 32'd160, 1'b1, 16'h0006, $urandom);
        send_request(OP_APPEND, 32'd160, 32'd160, 1'b0, 16'h0004, $urandom);
        send_request(OP_APPEND, 32'd160, 32'd160, 1'b0, 16'h0005, $urandom);
        send_request(OP_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'h8000, $urandom);
        send_request(OP_APPEND, 32'd0, 32'd0, 1'b0, 16'h00AA, $urandom);
        send_request(OP_LOOKUP, $urandom, $urandom, 1'b0, rnd_tag(), 32'd160);
        send_request(OP_LOOKUP, $urandom, $urandom, 1'b0, rnd_tag(), 32'd125);
        send_request(OP_LOOKUP, $urandom, $urandom, 1'b0, rnd_tag(), 32'd170);
        send_request(OP_LOOKUP, $urandom, $urandom, 1'b0, rnd_tag(), 32'd220);
        send_request(OP_LOOKUP, $urandom, $urandom, 1'b0, rnd_tag(), 32'd5);
        send_request(OP_LOOKUP, $urandom, $urandom, 1'b0, rnd_tag(), 32'hFFFF_FFFF);
        send_request(OP_LOOKUP, $urandom, $urandom, 1'b0, rnd_tag(), 32'd0);
        send_request(OP_LOOKUP, $urandom, $urandom, 1'b0, rnd_tag(), 32'd99);
        // clear, then the same lookup must miss
        send_request(OP_CLEAR, $urandom, $urandom, 1'b1, rnd_tag(), $urandom);
        send_request(OP_LOOKUP, $urandom, $urandom, 1'b0, rnd_tag(), 32'd160);

        // random batches; one long result hold-off, one full drain
        session = 0;
        while (sent < 200) begin
            if (session == 3)
                hold_request = 1'b1;
            if (session == 6) begin
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (pending != 0);
            end
            run_table_session($urandom_range(0, 4) != 0);
            session++;
        end

        // fill the table to the limit, overflow it, look up in the full table
        send_request(OP_CLEAR, $urandom, $urandom, 1'b1, rnd_tag(), $urandom);
        known_low.delete();
        known_high.delete();
        base = '0;
        for (int k = 0; k < ENTRIES_DEF + 2; k++) begin
            if (k % 32 == 0)
                base = pick_base();
            make_entry(base, lo, hi, is_rng, tag);
            if (k < ENTRIES_DEF) begin
                known_low.push_back(lo);
                known_high.push_back(hi);
            end
            send_request(OP_APPEND, lo, hi, is_rng, tag, $urandom);
        end
        // a malformed entry is refused as invalid even when full
        send_request(OP_APPEND, 32'd7, 32'd3, 1'b1, 16'h1234, $urandom);
        repeat (8)
            send_request(OP_LOOKUP, $urandom, $urandom, 1'b0, rnd_tag(), lookup_target());
        send_request(OP_LOOKUP, $urandom, $urandom, 1'b0, rnd_tag(), $urandom);
        send_request(OP_UNUSED, $urandom, $urandom, 1'b1, rnd_tag(), $urandom);

        while (sent < TOTAL_ITEMS - QUIET_ITEMS)
            run_table_session($urandom_range(0, 4) != 0);
        quiet = 1'b1;
        while (sent < TOTAL_ITEMS)
            run_table_session(1'b1);

        // drop valid, wait for the last results, then watch for stray ones
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial begin
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
